>>> sv/pdtt_pkg.sv
// ----------------------------------------------------------------------------
// pdtt_pkg
// Shared types and codes of the pending delivery timeout tracker: item kinds,
// result events, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package pdtt_pkg;

    typedef enum logic [1:0] {
        K_SEND  = 2'd0,
        K_ACK   = 2'd1,
        K_CHECK = 2'd2,
        K_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        EV_ASSIGNED     = 3'd0,
        EV_ACK_MATCH    = 3'd1,
        EV_ACK_MISS     = 3'd2,
        EV_TIMED_OUT    = 3'd3,
        EV_NONE_EXPIRED = 3'd4,
        EV_FULL         = 3'd5,
        EV_CLEARED      = 3'd6
    } t_event;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEND,
        S_CLEAR,
        S_ACK_RD,
        S_ACK_EV,
        S_CHK_RD,
        S_CHK_EV,
        S_CMP_RD,
        S_CMP_EV
    } t_state;

    typedef struct packed {
        logic load;
        logic send;
        logic clear;
        logic rd_up;
        logic rd_down;
        logic ack_ev;
        logic ack_miss;
        logic chk_ev;
        logic chk_end;
        logic cmp_ev;
        logic cmp_done;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_at_count;
        logic idx_zero;
        logic hit;
        logic nexp_zero;
    } t_dp_sts;

    localparam int TimeoutWidth = 16;
    localparam logic [TimeoutWidth-1:0] TimeoutReset = 16'd1000;
    localparam logic RegTimeout = 1'b0;

endpackage

>>> sv/pdtt_ctrl.sv
// ----------------------------------------------------------------------------
// pdtt_ctrl
// Sequencer of the tracker: decodes an accepted item and steps the datapath
// through table scans, result transfers and table compaction.
// ----------------------------------------------------------------------------
module pdtt_ctrl
    import pdtt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_kind,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    unique case (t_kind'(i_kind))
                        K_SEND:  n_state = S_SEND;
                        K_ACK:   n_state = S_ACK_RD;
                        K_CHECK: n_state = S_CHK_RD;
                        K_CLEAR: n_state = S_CLEAR;
                    endcase
                end
            end
            S_SEND: begin
                o_cmd.send = 1'b1;
                n_state    = S_IDLE;
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = S_IDLE;
            end
            S_ACK_RD: begin
                if (i_sts.idx_at_count) begin
                    o_cmd.ack_miss = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.rd_up = 1'b1;
                    n_state     = S_ACK_EV;
                end
            end
            S_ACK_EV: begin
                o_cmd.ack_ev = 1'b1;
                n_state      = i_sts.hit ? S_CMP_RD : S_ACK_RD;
            end
            S_CHK_RD: begin
                if (i_sts.idx_zero) begin
                    o_cmd.chk_end = 1'b1;
                    n_state       = i_sts.nexp_zero ? S_IDLE : S_CMP_RD;
                end else begin
                    o_cmd.rd_down = 1'b1;
                    n_state       = S_CHK_EV;
                end
            end
            S_CHK_EV: begin
                o_cmd.chk_ev = 1'b1;
                n_state      = S_CHK_RD;
            end
            S_CMP_RD: begin
                if (i_sts.idx_at_count) begin
                    o_cmd.cmp_done = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.rd_up = 1'b1;
                    n_state     = S_CMP_EV;
                end
            end
            S_CMP_EV: begin
                o_cmd.cmp_ev = 1'b1;
                n_state      = S_CMP_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/pdtt_dp.sv
// ----------------------------------------------------------------------------
// pdtt_dp
// Datapath of the tracker: entry memory (oldest first), counters, scan and
// compaction pointers, held timeout result and the registered result port.
// ----------------------------------------------------------------------------
module pdtt_dp
    import pdtt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    input  logic [1:0]              i_kind,
    input  logic [31:0]             i_ack_seq,
    input  logic [31:0]             i_now,
    input  logic [TimeoutWidth-1:0] i_timeout,
    output logic                    o_res_valid,
    output logic [2:0]              o_event_res,
    output logic [31:0]             o_seq,
    output logic [4:0]              o_pending,
    output logic                    o_last
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FullCount = CW'(TABLE_DEPTH);

    logic [63:0]   r_mem [TABLE_DEPTH];
    logic [63:0]   r_rd_data;

    t_kind         r_kind,     n_kind;
    logic [31:0]   r_ack_seq,  n_ack_seq;
    logic [31:0]   r_now,      n_now;
    logic [31:0]   r_next_seq, n_next_seq;
    logic [CW-1:0] r_count,    n_count;
    logic [CW-1:0] r_idx,      n_idx;
    logic [CW-1:0] r_wr,       n_wr;
    logic [CW-1:0] r_nexp,     n_nexp;
    logic          r_hold_v,   n_hold_v;
    logic [31:0]   r_hold_seq, n_hold_seq;
    logic [4:0]    r_hold_pend, n_hold_pend;
    logic          r_o_valid,  n_o_valid;
    t_event        r_o_event,  n_o_event;
    logic [31:0]   r_o_seq,    n_o_seq;
    logic [4:0]    r_o_pend,   n_o_pend;
    logic          r_o_last,   n_o_last;

    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [63:0]   mem_wd;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [31:0]   rd_seq;
    logic [31:0]   rd_dl;
    logic          expired;
    logic          seq_match;
    logic [32:0]   dl_sum;
    logic [31:0]   dl_sat;

    assign rd_seq    = r_rd_data[63:32];
    assign rd_dl     = r_rd_data[31:0];
    assign expired   = rd_dl < r_now;
    assign seq_match = rd_seq == r_ack_seq;
    assign dl_sum    = {1'b0, r_now} + {{(33 - TimeoutWidth){1'b0}}, i_timeout};
    assign dl_sat    = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];

    assign rd_en   = i_cmd.rd_up | i_cmd.rd_down;
    assign rd_addr = i_cmd.rd_down ? IW'(r_idx - 1'b1) : r_idx[IW-1:0];

    assign o_sts.idx_at_count = r_idx == r_count;
    assign o_sts.idx_zero     = r_idx == '0;
    assign o_sts.hit          = (r_kind == K_ACK) ? seq_match : expired;
    assign o_sts.nexp_zero    = r_nexp == '0;

    always_comb begin
        n_kind      = r_kind;
        n_ack_seq   = r_ack_seq;
        n_now       = r_now;
        n_next_seq  = r_next_seq;
        n_count     = r_count;
        n_idx       = r_idx;
        n_wr        = r_wr;
        n_nexp      = r_nexp;
        n_hold_v    = r_hold_v;
        n_hold_seq  = r_hold_seq;
        n_hold_pend = r_hold_pend;
        n_o_valid   = 1'b0;
        n_o_event   = r_o_event;
        n_o_seq     = r_o_seq;
        n_o_pend    = r_o_pend;
        n_o_last    = r_o_last;
        mem_we      = 1'b0;
        mem_wa      = '0;
        mem_wd      = '0;

        if (i_cmd.load) begin
            n_kind    = t_kind'(i_kind);
            n_ack_seq = i_ack_seq;
            n_now     = i_now;
            n_idx     = (t_kind'(i_kind) == K_CHECK) ? r_count : '0;
            n_nexp    = '0;
            n_hold_v  = 1'b0;
        end

        if (i_cmd.send) begin
            n_next_seq = r_next_seq + 32'd1;
            n_o_valid  = 1'b1;
            n_o_seq    = r_next_seq;
            n_o_last   = 1'b1;
            if (r_count != FullCount) begin
                mem_we    = 1'b1;
                mem_wa    = r_count[IW-1:0];
                mem_wd    = {r_next_seq, dl_sat};
                n_count   = r_count + 1'b1;
                n_o_event = EV_ASSIGNED;
                n_o_pend  = 5'(r_count + 1'b1);
            end else begin
                n_o_event = EV_FULL;
                n_o_pend  = 5'(r_count);
            end
        end

        if (i_cmd.clear) begin
            n_count   = '0;
            n_o_valid = 1'b1;
            n_o_event = EV_CLEARED;
            n_o_seq   = '0;
            n_o_pend  = '0;
            n_o_last  = 1'b1;
        end

        if (i_cmd.rd_down) begin
            n_idx = r_idx - 1'b1;
        end

        if (i_cmd.ack_ev) begin
            n_idx = r_idx + 1'b1;
            if (seq_match) begin
                n_wr      = r_idx;
                n_o_valid = 1'b1;
                n_o_event = EV_ACK_MATCH;
                n_o_seq   = r_ack_seq;
                n_o_pend  = 5'(r_count - 1'b1);
                n_o_last  = 1'b1;
            end
        end

        if (i_cmd.ack_miss) begin
            n_o_valid = 1'b1;
            n_o_event = EV_ACK_MISS;
            n_o_seq   = r_ack_seq;
            n_o_pend  = 5'(r_count);
            n_o_last  = 1'b1;
        end

        if (i_cmd.chk_ev && expired) begin
            n_nexp      = r_nexp + 1'b1;
            n_hold_v    = 1'b1;
            n_hold_seq  = rd_seq;
            n_hold_pend = 5'(r_count - r_nexp - 1'b1);
            if (r_hold_v) begin
                n_o_valid = 1'b1;
                n_o_event = EV_TIMED_OUT;
                n_o_seq   = r_hold_seq;
                n_o_pend  = r_hold_pend;
                n_o_last  = 1'b0;
            end
        end

        if (i_cmd.chk_end) begin
            n_idx     = '0;
            n_wr      = '0;
            n_hold_v  = 1'b0;
            n_o_valid = 1'b1;
            n_o_last  = 1'b1;
            if (r_hold_v) begin
                n_o_event = EV_TIMED_OUT;
                n_o_seq   = r_hold_seq;
                n_o_pend  = r_hold_pend;
            end else begin
                n_o_event = EV_NONE_EXPIRED;
                n_o_seq   = '0;
                n_o_pend  = 5'(r_count);
            end
        end

        if (i_cmd.cmp_ev) begin
            n_idx = r_idx + 1'b1;
            if (!(r_kind == K_CHECK && expired)) begin
                mem_we = 1'b1;
                mem_wa = r_wr[IW-1:0];
                mem_wd = r_rd_data;
                n_wr   = r_wr + 1'b1;
            end
        end

        if (i_cmd.cmp_done) begin
            n_count = r_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_seq <= '0;
            r_count    <= '0;
            r_hold_v   <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_next_seq <= n_next_seq;
            r_count    <= n_count;
            r_hold_v   <= n_hold_v;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_ack_seq   <= n_ack_seq;
        r_now       <= n_now;
        r_idx       <= n_idx;
        r_wr        <= n_wr;
        r_nexp      <= n_nexp;
        r_hold_seq  <= n_hold_seq;
        r_hold_pend <= n_hold_pend;
        r_o_event   <= n_o_event;
        r_o_seq     <= n_o_seq;
        r_o_pend    <= n_o_pend;
        r_o_last    <= n_o_last;
    end

    assign o_res_valid = r_o_valid;
    assign o_event_res = r_o_event;
    assign o_seq       = r_o_seq;
    assign o_pending   = r_o_pend;
    assign o_last      = r_o_last;

endmodule

>>> sv/pending_delivery_timeout_tracker.sv
// ----------------------------------------------------------------------------
// pending_delivery_timeout_tracker
// Sender-side tracker of pending deliveries with sequence numbers, acks and
// deadline expiry over a table of TABLE_DEPTH entries.
// Items enter as commands: i_kind, i_ack_seq and i_now transfer at an edge
// with start high and busy low. Results leave on o_event_res, o_seq,
// o_pending and o_last, each valid for one cycle while o_res_valid is high;
// the receiver takes every result and cannot stall the block.
// Steps of each item after it is accepted:
//   send, clear: the controller updates the table and registers the result.
//   ack:   ascending scan from the oldest entry, each entry read and then
//          compared; the first match is reported and the later entries are
//          then compacted; a miss is reported after the last entry.
//   check: descending scan from the newest entry; each expired entry is
//          reported when the next one is found or the scan ends, the final
//          result marked last; when any expire, an ascending compaction follows.
// One item at a time; every scan step waits for its registered read.
// timeout_interval is an APB register at byte address 0 (reset 1000).
// Reset empties the table and clears the sequence counter.
// ----------------------------------------------------------------------------
module pending_delivery_timeout_tracker
    import pdtt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_ack_seq,
    input  logic [31:0] i_now,
    output logic        o_res_valid,
    output logic [2:0]  o_event_res,
    output logic [31:0] o_seq,
    output logic [4:0]  o_pending,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [TimeoutWidth-1:0] r_timeout;
    logic [TimeoutWidth-1:0] n_timeout;
    t_dp_cmd                 cmd;
    t_dp_sts                 sts;

    assign pready = 1'b1;

    always_comb begin
        n_timeout = r_timeout;
        if (psel && penable && pwrite && paddr[2] == RegTimeout) begin
            n_timeout = pwdata[TimeoutWidth-1:0];
        end
        prdata = '0;
        if (paddr[2] == RegTimeout) begin
            prdata = {{(32 - TimeoutWidth){1'b0}}, r_timeout};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TimeoutReset;
        end else begin
            r_timeout <= n_timeout;
        end
    end

    pdtt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_kind  (i_kind),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pdtt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_kind      (i_kind),
        .i_ack_seq   (i_ack_seq),
        .i_now       (i_now),
        .i_timeout   (r_timeout),
        .o_res_valid (o_res_valid),
        .o_event_res (o_event_res),
        .o_seq       (o_seq),
        .o_pending   (o_pending),
        .o_last      (o_last)
    );

endmodule

>>> sv/pdtt_checker.sv
// ----------------------------------------------------------------------------
// pdtt_checker
// Port-level checks of the tracker: command acceptance, result framing and
// event codes.
// ----------------------------------------------------------------------------
module pdtt_checker
    import pdtt_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_res_valid,
    input logic [2:0] o_event_res,
    input logic [4:0] o_pending,
    input logic       o_last
);

    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy
    ) else $error("busy low after accepted command");

    a_result_needs_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(busy)
    ) else $error("result transfer without work in progress");

    a_single_results_last: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_event_res != EV_TIMED_OUT) |-> o_last
    ) else $error("single result not marked last");

    a_clear_empties: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_event_res == EV_CLEARED) |-> (o_pending == 5'd0)
    ) else $error("cleared result with entries pending");

    a_event_code: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_event_res != 3'd7)
    ) else $error("undefined event code");

endmodule

bind pending_delivery_timeout_tracker pdtt_checker u_pdtt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_res_valid (o_res_valid),
    .o_event_res (o_event_res),
    .o_pending   (o_pending),
    .o_last      (o_last)
);

>>> tb/pending_delivery_timeout_tracker_tb.sv
// ----------------------------------------------------------------------------
// pending_delivery_timeout_tracker_tb
// Self-checking bench for the pending delivery timeout tracker. A scoreboard
// mirrors the pending table, sequence counter and timeout register, and turns
// every accepted command into the results it must produce. Each result strobe
// is matched in order, field by field. A directed opening covers saturated
// deadlines, matched and unmatched acks, expiry, clear and a full table; the
// random part runs a moving clock across several timeout settings with
// random gaps, bursts and drains.
// ----------------------------------------------------------------------------
module pending_delivery_timeout_tracker_tb;
    import pdtt_pkg::*;

    localparam int DEPTH      = 16;
    localparam int CYCLE_CAP  = 400000;
    localparam int PHASE_LEN  = 78;
    localparam int NUM_PHASES = 5;

    typedef struct packed {
        t_event      ev;
        logic [31:0] seq;
        logic [4:0]  pend;
        logic        last;
    } t_tracker_result;

    class t_delivery_scoreboard;
        logic [15:0]     tmo = TimeoutReset;
        logic [31:0]     next_no = '0;
        logic [31:0]     ent_no[$];
        logic [31:0]     ent_deadline[$];
        t_tracker_result pending_results[$];
        int              mismatches = 0;

        function void push_result(t_event ev, logic [31:0] s, logic last);
            t_tracker_result r;
            r.ev   = ev;
            r.seq  = s;
            r.pend = 5'(ent_no.size());
            r.last = last;
            pending_results = {pending_results, r};
        endfunction

        function void track_item(t_kind k, logic [31:0] ack, logic [31:0] now);
            logic [32:0]     sum;
            logic [31:0]     s;
            logic [31:0]     dl;
            t_tracker_result r;
            int              idx;
            int              hits;
            int              i;
            case (k)
                K_SEND: begin
                    if (ent_no.size() < DEPTH) begin
                        sum = {1'b0, now} + {17'b0, tmo};
                        dl  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        ent_no       = {ent_no, next_no};
                        ent_deadline = {ent_deadline, dl};
                        push_result(EV_ASSIGNED, next_no, 1'b1);
                    end else begin
                        push_result(EV_FULL, next_no, 1'b1);
                    end
                    next_no = next_no + 32'd1;
                end
                K_ACK: begin
                    idx = -1;
                    for (i = 0; i < ent_no.size(); i++) begin
                        if (idx < 0 && ent_no[i] == ack) idx = i;
                    end
                    if (idx >= 0) begin
                        ent_no.delete(idx);
                        ent_deadline.delete(idx);
                        push_result(EV_ACK_MATCH, ack, 1'b1);
                    end else begin
                        push_result(EV_ACK_MISS, ack, 1'b1);
                    end
                end
                K_CHECK: begin
                    hits = 0;
                    for (i = ent_no.size() - 1; i >= 0; i--) begin
                        if (ent_deadline[i] < now) begin
                            s = ent_no[i];
                            ent_no.delete(i);
                            ent_deadline.delete(i);
                            push_result(EV_TIMED_OUT, s, 1'b0);
                            hits++;
                        end
                    end
                    if (hits == 0) begin
                        push_result(EV_NONE_EXPIRED, 32'd0, 1'b1);
                    end else begin
                        r = pending_results.pop_back();
                        r.last = 1'b1;
                        pending_results = {pending_results, r};
                    end
                end
                default: begin
                    ent_no.delete();
                    ent_deadline.delete();
                    push_result(EV_CLEARED, 32'd0, 1'b1);
                end
            endcase
        endfunction

        function void match_result(logic [2:0] ev, logic [31:0] s, logic [4:0] p, logic l);
            t_tracker_result want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: ev=%0d seq=%h pending=%0d last=%b",
                             ev, s, p, l);
                return;
            end
            want = pending_results.pop_front();
            if (ev !== want.ev || s !== want.seq || p !== want.pend || l !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp ev=%0d seq=%h pending=%0d last=%b, ",
                             want.ev, want.seq, want.pend, want.last,
                             "got ev=%0d seq=%h pending=%0d last=%b",
                             ev, s, p, l);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_kind;
    logic [31:0] i_ack_seq;
    logic [31:0] i_now;
    logic        o_res_valid;
    logic [2:0]  o_event_res;
    logic [31:0] o_seq;
    logic [4:0]  o_pending;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_delivery_scoreboard sb = new();
    logic [31:0]          tick;
    int                   burst_left;
    int                   cycles;

    pending_delivery_timeout_tracker #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_ack_seq   (i_ack_seq),
        .i_now       (i_now),
        .o_res_valid (o_res_valid),
        .o_event_res (o_event_res),
        .o_seq       (o_seq),
        .o_pending   (o_pending),
        .o_last      (o_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_res_valid) sb.match_result(o_event_res, o_seq, o_pending, o_last);
            if (start && !busy) sb.track_item(t_kind'(i_kind), i_ack_seq, i_now);
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_CAP) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("pending_delivery_timeout_tracker_tb: done, errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            burst_left = 20;
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // hold start until the transfer, then idle for the gap
    task automatic drive_item(t_kind k, logic [31:0] ack, logic [31:0] now);
        int g;
        g = pick_gap();
        start     <= 1'b1;
        i_kind    <= k;
        i_ack_seq <= ack;
        i_now     <= now;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // drop start, wait out every result and the trailing compaction
    task automatic settle();
        if (start) start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_transfer(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= 3'd4 * RegTimeout;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_timeout(logic [31:0] value);
        logic [31:0] rd;
        apb_transfer(1'b1, value, rd);
        sb.tmo = value[15:0];
        apb_transfer(1'b0, 32'd0, rd);
        if (rd !== {16'd0, value[15:0]}) begin
            sb.mismatches++;
            if (sb.mismatches <= 10)
                $display("timeout readback: exp %h got %h", {16'd0, value[15:0]}, rd);
        end
    endtask

    task automatic random_item();
        int          r;
        int          step;
        logic [31:0] ack;
        step = int'(sb.tmo) / 4 + 3;
        tick = tick + 32'($urandom_range(0, step));
        if ($urandom_range(0, 99) < 3)
            tick = 32'hFFFF_FFFF - 32'($urandom_range(0, 2 * int'(sb.tmo) + 4));
        r = $urandom_range(0, 99);
        if (r < 42) begin
            drive_item(K_SEND, $urandom, ($urandom_range(0, 19) == 0) ? $urandom : tick);
        end else if (r < 70) begin
            r = $urandom_range(0, 99);
            if (r < 70 && sb.ent_no.size() > 0)
                ack = sb.ent_no[$urandom_range(0, sb.ent_no.size() - 1)];
            else if (r < 85)
                ack = sb.next_no - 32'($urandom_range(1, 40));
            else
                ack = $urandom;
            drive_item(K_ACK, ack, $urandom);
        end else if (r < 95) begin
            drive_item(K_CHECK, $urandom, ($urandom_range(0, 9) == 0) ? $urandom : tick);
        end else begin
            drive_item(K_CLEAR, $urandom, $urandom);
        end
        if ($urandom_range(0, 99) < 2) settle();
    endtask

    initial begin
        logic [31:0] phase_tmo[NUM_PHASES];
        int          i;
        int          ph;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_kind     = K_SEND;
        i_ack_seq  = '0;
        i_now      = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        tick       = '0;
        burst_left = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: saturation, ack hit and miss, expiry, clear, full table
        drive_item(K_SEND, 32'h0, 32'h0);
        drive_item(K_SEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drive_item(K_ACK, 32'd1, 32'h0);
        drive_item(K_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drive_item(K_CHECK, 32'h0, 32'h0);
        drive_item(K_CHECK, 32'h0, 32'd1001);
        drive_item(K_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (i = 0; i < DEPTH; i++) drive_item(K_SEND, 32'h0, 32'(i));
        drive_item(K_SEND, 32'h0, 32'd20);
        drive_item(K_CHECK, 32'h0, 32'hFFFF_FFFF);
        settle();

        phase_tmo[0] = {16'd0, TimeoutReset};
        phase_tmo[1] = 32'h0000_0000;
        phase_tmo[2] = 32'hFFFF_FFFF;
        phase_tmo[3] = 32'h0000_0001;
        phase_tmo[4] = 32'($urandom_range(2, 65534));
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) set_timeout(phase_tmo[ph]);
            for (i = 0; i < PHASE_LEN; i++) random_item();
            settle();
        end

        repeat (80) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("pending_delivery_timeout_tracker_tb: done, clean");
        end else begin
            $display("pending_delivery_timeout_tracker_tb: done, errors");
        end
        $finish;
    end

endmodule

>>> files.f
sv/pdtt_pkg.sv
sv/pdtt_ctrl.sv
sv/pdtt_dp.sv
sv/pending_delivery_timeout_tracker.sv
sv/pdtt_checker.sv
tb/pending_delivery_timeout_tracker_tb.sv
